// File: src/ppas_pkg.sv
// Shared types and constants for the pick-and-place arm sequencer.
package ppas_pkg;

  typedef enum logic [3:0] {
    PH_POWER_ON  = 4'd0,
    PH_REQ_BOX   = 4'd1,
    PH_MOVE_BOX  = 4'd2,
    PH_GRIP      = 4'd3,
    PH_REQ_DEST  = 4'd4,
    PH_MOVE_DEST = 4'd5,
    PH_RELEASE   = 4'd6,
    PH_ASK       = 4'd7,
    PH_HOMING    = 4'd8,
    PH_OFF       = 4'd9
  } phase_t;

  localparam int unsigned PHASE_WIDTH = 4;

endpackage

// File: src/ppas_axis.sv
// One axis of the arm: a single unit step toward the goal.
module ppas_axis #(
  parameter int unsigned WIDTH = 12
) (
  input  logic signed [WIDTH-1:0] pos,
  input  logic signed [WIDTH-1:0] goal,
  output logic signed [WIDTH-1:0] stepped
);

  always_comb begin
    if (pos < goal) begin
      stepped = pos + WIDTH'(1);
    end else if (pos > goal) begin
      stepped = pos - WIDTH'(1);
    end else begin
      stepped = pos;
    end
  end

endmodule

// File: src/pick_place_arm_sequencer_unit.sv
// Pick-and-place arm sequencer: one request per motion tick, one result per request.
// Flow: a request is taken into the hold register and processed from there into the result
//   register; one request enters per cycle while the result is not stalled, set by the
//   combinational axis step and compare between the hold and result registers.
// Reset (rst, synchronous, active high): power-on phase, arm and goal at zero,
//   gripper open, both stages empty.
module pick_place_arm_sequencer_unit #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] target_z,
  input  logic                          repeat_request,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ppas_pkg::PHASE_WIDTH-1:0] phase,
  output logic signed [COORD_WIDTH-1:0] pos_x,
  output logic signed [COORD_WIDTH-1:0] pos_y,
  output logic signed [COORD_WIDTH-1:0] pos_z,
  output logic                          gripper_closed,
  output logic                          at_target
);

  // Home position used at power-on and for the final homing move.
  localparam logic signed [COORD_WIDTH-1:0] HOME = COORD_WIDTH'(1);

  // Hold register: the request waiting for the sequencer.
  logic                          held_valid;
  logic signed [COORD_WIDTH-1:0] held_x;
  logic signed [COORD_WIDTH-1:0] held_y;
  logic signed [COORD_WIDTH-1:0] held_z;
  logic                          held_repeat;

  // Sequencer state. The arm position and gripper are the result payload too:
  // they change only when a request is processed, which needs the result
  // register free, so a stalled result never moves.
  ppas_pkg::phase_t              phase_reg;
  logic signed [COORD_WIDTH-1:0] goal_x;
  logic signed [COORD_WIDTH-1:0] goal_y;
  logic signed [COORD_WIDTH-1:0] goal_z;

  ppas_pkg::phase_t              phase_next;
  logic signed [COORD_WIDTH-1:0] pos_x_next;
  logic signed [COORD_WIDTH-1:0] pos_y_next;
  logic signed [COORD_WIDTH-1:0] pos_z_next;
  logic signed [COORD_WIDTH-1:0] goal_x_next;
  logic signed [COORD_WIDTH-1:0] goal_y_next;
  logic signed [COORD_WIDTH-1:0] goal_z_next;
  logic                          grip_next;
  logic                          at_target_next;

  logic signed [COORD_WIDTH-1:0] step_x;
  logic signed [COORD_WIDTH-1:0] step_y;
  logic signed [COORD_WIDTH-1:0] step_z;
  logic                          step_done;

  logic                          advance;

  // Process the held request when the result register is empty or draining.
  assign advance   = held_valid && (!out_valid || !out_stall);
  assign in_stall  = held_valid && !advance;
  assign phase     = phase_reg;

  // ---------------------------------------------------------------------------
  // Per-axis unit step toward the goal
  // ---------------------------------------------------------------------------
  ppas_axis #(.WIDTH(COORD_WIDTH)) u_axis_x (.pos(pos_x), .goal(goal_x), .stepped(step_x));
  ppas_axis #(.WIDTH(COORD_WIDTH)) u_axis_y (.pos(pos_y), .goal(goal_y), .stepped(step_y));
  ppas_axis #(.WIDTH(COORD_WIDTH)) u_axis_z (.pos(pos_z), .goal(goal_z), .stepped(step_z));

  // Move states leave in the same tick in which all axes arrive.
  assign step_done = (step_x == goal_x) && (step_y == goal_y) && (step_z == goal_z);

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_next  = phase_reg;
    pos_x_next  = pos_x;
    pos_y_next  = pos_y;
    pos_z_next  = pos_z;
    goal_x_next = goal_x;
    goal_y_next = goal_y;
    goal_z_next = goal_z;
    grip_next   = gripper_closed;
    unique case (phase_reg)
      ppas_pkg::PH_POWER_ON: begin
        pos_x_next = HOME;
        pos_y_next = HOME;
        pos_z_next = HOME;
        phase_next = ppas_pkg::PH_REQ_BOX;
      end
      ppas_pkg::PH_REQ_BOX: begin
        goal_x_next = held_x;
        goal_y_next = held_y;
        goal_z_next = held_z;
        phase_next  = ppas_pkg::PH_MOVE_BOX;
      end
      ppas_pkg::PH_MOVE_BOX: begin
        pos_x_next = step_x;
        pos_y_next = step_y;
        pos_z_next = step_z;
        if (step_done) begin
          phase_next = ppas_pkg::PH_GRIP;
        end
      end
      ppas_pkg::PH_GRIP: begin
        grip_next  = 1'b1;
        phase_next = ppas_pkg::PH_REQ_DEST;
      end
      ppas_pkg::PH_REQ_DEST: begin
        goal_x_next = held_x;
        goal_y_next = held_y;
        goal_z_next = held_z;
        phase_next  = ppas_pkg::PH_MOVE_DEST;
      end
      ppas_pkg::PH_MOVE_DEST: begin
        pos_x_next = step_x;
        pos_y_next = step_y;
        pos_z_next = step_z;
        if (step_done) begin
          phase_next = ppas_pkg::PH_RELEASE;
        end
      end
      ppas_pkg::PH_RELEASE: begin
        grip_next  = 1'b0;
        phase_next = ppas_pkg::PH_ASK;
      end
      ppas_pkg::PH_ASK: begin
        if (held_repeat) begin
          phase_next = ppas_pkg::PH_REQ_BOX;
        end else begin
          goal_x_next = HOME;
          goal_y_next = HOME;
          goal_z_next = HOME;
          phase_next  = ppas_pkg::PH_HOMING;
        end
      end
      ppas_pkg::PH_HOMING: begin
        pos_x_next = step_x;
        pos_y_next = step_y;
        pos_z_next = step_z;
        if (step_done) begin
          phase_next = ppas_pkg::PH_OFF;
        end
      end
      default: begin
        // off, and the unused codes, settle in off
        phase_next = ppas_pkg::PH_OFF;
      end
    endcase
  end

  assign at_target_next = (pos_x_next == goal_x_next) && (pos_y_next == goal_y_next) &&
                          (pos_z_next == goal_z_next);

  // ---------------------------------------------------------------------------
  // Hold register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      held_x      <= target_x;
      held_y      <= target_y;
      held_z      <= target_z;
      held_repeat <= repeat_request;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      phase_reg      <= ppas_pkg::PH_POWER_ON;
      pos_x          <= '0;
      pos_y          <= '0;
      pos_z          <= '0;
      goal_x         <= '0;
      goal_y         <= '0;
      goal_z         <= '0;
      gripper_closed <= 1'b0;
      at_target      <= 1'b0;
    end else if (advance) begin
      out_valid      <= 1'b1;
      phase_reg      <= phase_next;
      pos_x          <= pos_x_next;
      pos_y          <= pos_y_next;
      pos_z          <= pos_z_next;
      goal_x         <= goal_x_next;
      goal_y         <= goal_y_next;
      goal_z         <= goal_z_next;
      gripper_closed <= grip_next;
      at_target      <= at_target_next;
    end else if (!out_stall) begin
      out_valid      <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // Gripper is closed only between grip and release; the release step opens it.
  a_grip_phase: assert property (@(posedge clk) disable iff (rst)
    gripper_closed |-> (phase_reg == ppas_pkg::PH_REQ_DEST ||
                        phase_reg == ppas_pkg::PH_MOVE_DEST ||
                        phase_reg == ppas_pkg::PH_RELEASE))
    else $error("gripper closed outside the carry phases");

  // Off is sticky.
  a_off_sticky: assert property (@(posedge clk) disable iff (rst)
    phase_reg == ppas_pkg::PH_OFF |=> phase_reg == ppas_pkg::PH_OFF)
    else $error("left the off phase");

  // Arm holds still unless a request is processed.
  a_hold_still: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(pos_x) && $stable(pos_y) && $stable(pos_z) &&
                  $stable(phase_reg)))
    else $error("state moved without a request");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the pick-and-place arm sequencer.
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_WIDTH = 12;
  localparam int COORD_MIN   = -(1 << (COORD_WIDTH - 1));
  localparam int COORD_MAX   = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int HOME_COORD  = 1;     // home point is (1,1,1)
  localparam int HOLD_CYCLES = 300;   // long result hold-off under pressure
  localparam int TRIP_REACH  = 300;   // per-axis distance of the long trips

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One step outcome as the block reports it.
  typedef struct packed {
    logic [ppas_pkg::PHASE_WIDTH-1:0] phase;
    coord_t                           pos_x;
    coord_t                           pos_y;
    coord_t                           pos_z;
    logic                             grip;
    logic                             at_goal;
  } arm_result_t;

  // Receiver stall behaviour, reselected every so often.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_mode_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t target_x = '0;
  coord_t target_y = '0;
  coord_t target_z = '0;
  logic   repeat_request = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic [ppas_pkg::PHASE_WIDTH-1:0] phase;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic   gripper_closed;
  logic   at_target;

  pick_place_arm_sequencer_unit #(.COORD_WIDTH(COORD_WIDTH)) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_x       (target_x),
    .target_y       (target_y),
    .target_z       (target_z),
    .repeat_request (repeat_request),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .phase          (phase),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .gripper_closed (gripper_closed),
    .at_target      (at_target)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Arm tracker: our own copy of the sequencer state, advanced once per
  // accepted request. Coordinates are held as int; the goal always lies in
  // range so the position never leaves it either.
  // ---------------------------------------------------------------------------
  ppas_pkg::phase_t arm_phase = ppas_pkg::PH_POWER_ON;
  int     arm_pos[3]  = '{0, 0, 0};
  int     arm_goal[3] = '{0, 0, 0};
  logic   arm_grip    = 1'b0;

  arm_result_t expected_moves[$];   // outcomes still owed by the block
  int          mismatch_count = 0;

  function automatic logic arm_on_goal();
    return arm_pos[0] == arm_goal[0] && arm_pos[1] == arm_goal[1] &&
           arm_pos[2] == arm_goal[2];
  endfunction

  // One unit per axis toward the goal; reports arrival on all three axes.
  function automatic logic nudge_axes();
    for (int a = 0; a < 3; a++) begin
      if (arm_pos[a] < arm_goal[a]) arm_pos[a] = arm_pos[a] + 1;
      else if (arm_pos[a] > arm_goal[a]) arm_pos[a] = arm_pos[a] - 1;
    end
    return arm_on_goal();
  endfunction

  function automatic arm_result_t advance_arm(input coord_t tx, input coord_t ty,
                                              input coord_t tz, input logic rep);
    arm_result_t r;
    case (arm_phase)
      ppas_pkg::PH_POWER_ON: begin
        // arm jumps to home, goal untouched
        arm_pos   = '{HOME_COORD, HOME_COORD, HOME_COORD};
        arm_phase = ppas_pkg::PH_REQ_BOX;
      end
      ppas_pkg::PH_REQ_BOX: begin
        arm_goal  = '{int'(tx), int'(ty), int'(tz)};
        arm_phase = ppas_pkg::PH_MOVE_BOX;
      end
      ppas_pkg::PH_MOVE_BOX: begin
        if (nudge_axes()) arm_phase = ppas_pkg::PH_GRIP;
      end
      ppas_pkg::PH_GRIP: begin
        arm_grip  = 1'b1;
        arm_phase = ppas_pkg::PH_REQ_DEST;
      end
      ppas_pkg::PH_REQ_DEST: begin
        arm_goal  = '{int'(tx), int'(ty), int'(tz)};
        arm_phase = ppas_pkg::PH_MOVE_DEST;
      end
      ppas_pkg::PH_MOVE_DEST: begin
        if (nudge_axes()) arm_phase = ppas_pkg::PH_RELEASE;
      end
      ppas_pkg::PH_RELEASE: begin
        arm_grip  = 1'b0;
        arm_phase = ppas_pkg::PH_ASK;
      end
      ppas_pkg::PH_ASK: begin
        if (rep) begin
          arm_phase = ppas_pkg::PH_REQ_BOX;
        end else begin
          arm_goal  = '{HOME_COORD, HOME_COORD, HOME_COORD};
          arm_phase = ppas_pkg::PH_HOMING;
        end
      end
      ppas_pkg::PH_HOMING: begin
        if (nudge_axes()) arm_phase = ppas_pkg::PH_OFF;
      end
      default: begin
        arm_phase = ppas_pkg::PH_OFF;   // off is sticky
      end
    endcase
    r.phase   = arm_phase;
    r.pos_x   = coord_t'(arm_pos[0]);
    r.pos_y   = coord_t'(arm_pos[1]);
    r.pos_z   = coord_t'(arm_pos[2]);
    r.grip    = arm_grip;
    r.at_goal = arm_on_goal();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Bursts of random length with random gaps; sender_eager
  // suppresses gaps for calm stretches and for the pressure phase.
  // ---------------------------------------------------------------------------
  int   burst_left   = 0;
  logic sender_eager = 1'b0;

  // Present one request and hold it until taken, then log its outcome.
  task automatic offer_step(input coord_t tx, input coord_t ty, input coord_t tz,
                            input logic rep);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!sender_eager && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    target_x       <= tx;
    target_y       <= ty;
    target_z       <= tz;
    repeat_request <= rep;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_moves.push_back(advance_arm(tx, ty, tz, rep));
  endtask

  // Target coordinate a short way from the current one, kept in range.
  function automatic coord_t near_coord(input int centre);
    int pick;
    int off;
    pick = $urandom_range(0, 99);
    if (pick < 10)      off = 0;
    else if (pick < 88) off = int'($urandom_range(0, 12)) - 6;
    else if (pick < 97) off = int'($urandom_range(0, 120)) - 60;
    else                off = int'($urandom_range(0, 600)) - 300;
    off = centre + off;
    if (off < COORD_MIN) off = COORD_MIN;
    if (off > COORD_MAX) off = COORD_MAX;
    return coord_t'(off);
  endfunction

  // Request shaped by the tracked phase: nearby goals in the request states,
  // always carry on when asked, random noise everywhere the fields are ignored.
  task automatic send_auto();
    coord_t tx;
    coord_t ty;
    coord_t tz;
    tx = coord_t'($urandom);
    ty = coord_t'($urandom);
    tz = coord_t'($urandom);
    if (arm_phase == ppas_pkg::PH_REQ_BOX || arm_phase == ppas_pkg::PH_REQ_DEST) begin
      if ($urandom_range(0, 9) == 0) begin
        // goal where the arm already stands
        tx = coord_t'(arm_pos[0]);
        ty = coord_t'(arm_pos[1]);
        tz = coord_t'(arm_pos[2]);
      end else begin
        tx = near_coord(arm_pos[0]);
        ty = near_coord(arm_pos[1]);
        tz = near_coord(arm_pos[2]);
      end
    end
    if (arm_phase == ppas_pkg::PH_ASK) offer_step(tx, ty, tz, 1'b1);
    else offer_step(tx, ty, tz, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_until(input ppas_pkg::phase_t goal_phase);
    while (arm_phase != goal_phase) send_auto();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern of its own, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  int       hold_asked  = 0;
  int       hold_served = 0;
  int       hold_left   = 0;
  int       mode_left   = 0;
  rx_mode_t rx_mode     = RX_FREE;
  logic     rx_toggle   = 1'b0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
      end
      mode_left = mode_left - 1;
      rx_toggle = ~rx_toggle;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= rx_toggle;
      endcase
    end
  end

  // Compare each taken result with the oldest owed outcome.
  always @(posedge clk) begin : result_check
    arm_result_t got;
    arm_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{phase, pos_x, pos_y, pos_z, gripper_closed, at_target};
      if (expected_moves.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing owed: phase %0d pos %0d,%0d,%0d grip %b at %b",
                   $realtime, got.phase, got.pos_x, got.pos_y, got.pos_z, got.grip,
                   got.at_goal);
      end else begin
        want = expected_moves.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch exp phase %0d pos %0d,%0d,%0d grip %b at %b",
                      " / got phase %0d pos %0d,%0d,%0d grip %b at %b"},
                     $realtime, want.phase, want.pos_x, want.pos_y, want.pos_z,
                     want.grip, want.at_goal, got.phase, got.pos_x, got.pos_y,
                     got.pos_z, got.grip, got.at_goal);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // First request after reset: arm jumps home, goal still at the origin.
  task automatic test_power_on();
    offer_step(coord_t'(COORD_MIN), coord_t'(COORD_MAX), '0, 1'b0);
  endtask

  // A full cycle where every goal is where the arm already stands, so both
  // moves finish in the tick they start.
  task automatic test_zero_distance();
    offer_step(coord_t'(HOME_COORD), coord_t'(HOME_COORD), coord_t'(HOME_COORD), 1'b0);
    send_auto();   // move to box, already there
    send_auto();   // grip
    offer_step(coord_t'(HOME_COORD), coord_t'(HOME_COORD), coord_t'(HOME_COORD), 1'b1);
    send_auto();   // move to destination, already there
    send_auto();   // release
    offer_step(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1'b1);
  endtask

  // Long trips: out into one octant, then straight across to the opposite one.
  task automatic test_extreme_trip();
    offer_step(coord_t'(-TRIP_REACH), coord_t'(TRIP_REACH), coord_t'(-TRIP_REACH), 1'b0);
    run_until(ppas_pkg::PH_REQ_DEST);
    offer_step(coord_t'(TRIP_REACH), coord_t'(-TRIP_REACH), coord_t'(TRIP_REACH), 1'b1);
    run_until(ppas_pkg::PH_ASK);
    offer_step(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1'b1);
  endtask

  // Many short box cycles with random goals; a long result hold-off a quarter of the
  // way through while requests keep coming, so the block backs up.
  task automatic test_random_steps(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) sender_eager = ($urandom_range(0, 2) == 0);
      if (i == count / 4) begin
        sender_eager = 1'b1;
        hold_asked++;
      end
      send_auto();
    end
    sender_eager = 1'b0;
  endtask

  // Decline another box: home and switch off, then check off holds.
  task automatic test_shutdown();
    run_until(ppas_pkg::PH_REQ_DEST);
    offer_step(coord_t'(5), coord_t'(-3), coord_t'(9), 1'b1);
    run_until(ppas_pkg::PH_ASK);
    offer_step(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1'b0);
    run_until(ppas_pkg::PH_OFF);
    repeat (6) send_auto();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_power_on();
    test_zero_distance();
    test_extreme_trip();
    test_random_steps(650);
    test_shutdown();

    in_valid <= 1'b0;
    // drain, then wait on to catch anything extra
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && expected_moves.size() == 0) begin
      $display("PASS pick_place_arm_sequencer_unit");
    end else begin
      $display("FAIL pick_place_arm_sequencer_unit");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL pick_place_arm_sequencer_unit");
    $finish;
  end

endmodule
